/* hw/rtl/bes_pkg.sv */
// Shared types, codes and constants for the box edge snap block.
package bes_pkg;

  localparam int THR_WIDTH  = 12;
  localparam int MASK_WIDTH = 4;
  localparam int IDX_WIDTH  = 3;
  localparam int NUM_SLOTS  = 4;

  localparam int OFS_LEFT   = 0;
  localparam int OFS_RIGHT  = 1;
  localparam int OFS_TOP    = 2;
  localparam int OFS_BOTTOM = 3;

  localparam int EDGE_BIT_LEFT   = 0;
  localparam int EDGE_BIT_RIGHT  = 1;
  localparam int EDGE_BIT_TOP    = 2;
  localparam int EDGE_BIT_BOTTOM = 3;

  localparam logic [MASK_WIDTH-1:0] EDGE_ALL   = 4'hF;
  localparam logic [THR_WIDTH-1:0]  THR_OFF    = '0;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_FREE_LEFT   = 3'd0,
    REG_FREE_TOP    = 3'd1,
    REG_FREE_RIGHT  = 3'd2,
    REG_FREE_BOTTOM = 3'd3,
    REG_THRESHOLD   = 3'd4,
    REG_EDGE_MASK   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REQ_START    = 1'b0,
    REQ_NEIGHBOR = 1'b1
  } req_type_e;

  typedef struct packed {
    logic clear;
    logic en_own;
    logic en_other;
  } offer_ctl_t;

  function automatic int calc_dw(int cw, int ow);
    int m;
    m = cw + 2;
    if (THR_WIDTH + 2 > m) m = THR_WIDTH + 2;
    if (ow + 2 > m) m = ow + 2;
    return m + 1;
  endfunction

endpackage

/* hw/rtl/bes_slot.sv */
// One snap slot: keeps the closest offset for one edge and folds in new offers.
module bes_slot #(
  parameter int COORD_WIDTH  = 16,
  parameter int OFFSET_WIDTH = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                update_i,
  input  bes_pkg::offer_ctl_t                 ctl_i,
  input  logic [bes_pkg::THR_WIDTH-1:0]       thr_i,
  input  logic signed [COORD_WIDTH-1:0]       fix_i,
  input  logic signed [COORD_WIDTH-1:0]       own_i,
  input  logic signed [COORD_WIDTH-1:0]       other_i,
  output logic                                found_o,
  output logic signed [OFFSET_WIDTH-1:0]      best_o
);

  localparam int DW = bes_pkg::calc_dw(COORD_WIDTH, OFFSET_WIDTH);

  logic                           found_q, found_d;
  logic signed [OFFSET_WIDTH-1:0] best_q, best_d;
  logic signed [DW-1:0]           off_own, off_other;
  logic                           f0, f1, t1, t2;
  logic signed [OFFSET_WIDTH-1:0] b1;

  function automatic logic take(logic found, logic signed [DW-1:0] off,
                                logic signed [OFFSET_WIDTH-1:0] best,
                                logic [bes_pkg::THR_WIDTH-1:0] thr);
    logic signed [DW-1:0] bx;
    logic [DW-1:0]        m_off, m_best;
    bx     = DW'(best);
    m_off  = off[DW-1] ? -off : off;
    m_best = bx[DW-1] ? -bx : bx;
    return (m_off <= DW'(thr)) && (!found || (m_off < m_best));
  endfunction

  assign off_own   = DW'(own_i) - DW'(fix_i);
  assign off_other = DW'(other_i) - DW'(fix_i);

  always_comb begin
    f0      = ctl_i.clear ? 1'b0 : found_q;
    t1      = ctl_i.en_own && take(f0, off_own, best_q, thr_i);
    f1      = f0 | t1;
    b1      = t1 ? off_own[OFFSET_WIDTH-1:0] : best_q;
    t2      = ctl_i.en_other && take(f1, off_other, b1, thr_i);
    found_d = f1 | t2;
    best_d  = t2 ? off_other[OFFSET_WIDTH-1:0] : b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (update_i) begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_i) begin
      best_q <= best_d;
    end
  end

  assign found_o = found_d;
  assign best_o  = best_d;

endmodule

/* hw/rtl/box_edge_snap.sv */
// Top level of the box edge snap block: registers, offer control and result stage.
// A beat waits in the input register while the four snap slots fold its edges into their kept
// offsets, and the snapped box lands in the output register as the beat advances, so a new beat
// can enter every cycle as long as results are taken. A beat passes the input register, then the
// output register, and can be held in either by a stall. Slot state is updated as the beat moves
// to the output register, so every result reflects all beats accepted before it.
module box_edge_snap #(
  parameter int COORD_WIDTH  = 16,
  parameter int OFFSET_WIDTH = 13,
  localparam int CFG_WIDTH   = (COORD_WIDTH > bes_pkg::THR_WIDTH) ?
                               COORD_WIDTH : bes_pkg::THR_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bes_pkg::IDX_WIDTH-1:0]     cfg_index_i,
  input  logic [CFG_WIDTH-1:0]              cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [COORD_WIDTH-1:0]     box_left_i,
  input  logic signed [COORD_WIDTH-1:0]     box_top_i,
  input  logic signed [COORD_WIDTH-1:0]     box_right_i,
  input  logic signed [COORD_WIDTH-1:0]     box_bottom_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COORD_WIDTH-1:0]     snap_left_o,
  output logic signed [COORD_WIDTH-1:0]     snap_top_o,
  output logic signed [COORD_WIDTH-1:0]     snap_right_o,
  output logic signed [COORD_WIDTH-1:0]     snap_bottom_o
);

  localparam int DW = bes_pkg::calc_dw(COORD_WIDTH, OFFSET_WIDTH);
  localparam logic signed [DW-1:0] CMAX = {{(DW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [DW-1:0] CMIN = ~CMAX;

  logic signed [COORD_WIDTH-1:0]       free_left_q, free_top_q, free_right_q, free_bottom_q;
  logic [bes_pkg::THR_WIDTH-1:0]       thr_q;
  logic [bes_pkg::MASK_WIDTH-1:0]      edge_mask_q;

  logic                                s1_valid_q;
  logic                                req_q;
  logic signed [COORD_WIDTH-1:0]       box_left_q, box_top_q, box_right_q, box_bottom_q;
  logic                                advance;

  logic                                out_valid_q;
  logic signed [COORD_WIDTH-1:0]       snap_left_q, snap_top_q, snap_right_q, snap_bottom_q;
  logic signed [COORD_WIDTH-1:0]       snap_left_d, snap_top_d, snap_right_d, snap_bottom_d;

  logic                                near_v, near_h, is_start;
  logic signed [COORD_WIDTH-1:0]       slot_fix   [bes_pkg::NUM_SLOTS];
  logic signed [COORD_WIDTH-1:0]       slot_own   [bes_pkg::NUM_SLOTS];
  logic signed [COORD_WIDTH-1:0]       slot_other [bes_pkg::NUM_SLOTS];
  bes_pkg::offer_ctl_t                 slot_ctl   [bes_pkg::NUM_SLOTS];
  logic                                slot_found [bes_pkg::NUM_SLOTS];
  logic signed [OFFSET_WIDTH-1:0]      slot_best  [bes_pkg::NUM_SLOTS];

  logic signed [DW-1:0]                dx, dy, g;

  function automatic logic [DW-1:0] magw(logic signed [DW-1:0] v);
    return v[DW-1] ? -v : v;
  endfunction

  function automatic logic signed [DW-1:0] choose(logic f_lo, logic signed [OFFSET_WIDTH-1:0] b_lo,
                                                  logic f_hi,
                                                  logic signed [OFFSET_WIDTH-1:0] b_hi);
    logic signed [DW-1:0] lo, hi;
    lo = DW'(b_lo);
    hi = DW'(b_hi);
    if (f_lo && f_hi) return (magw(hi) < magw(lo)) ? hi : lo;
    if (f_lo) return lo;
    if (f_hi) return hi;
    return '0;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat(logic signed [DW-1:0] v);
    if (v > CMAX) return CMAX[COORD_WIDTH-1:0];
    if (v < CMIN) return CMIN[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_left_q   <= '0;
      free_top_q    <= '0;
      free_right_q  <= '0;
      free_bottom_q <= '0;
      thr_q         <= '0;
      edge_mask_q   <= bes_pkg::EDGE_ALL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bes_pkg::REG_FREE_LEFT:   free_left_q   <= cfg_data_i[COORD_WIDTH-1:0];
        bes_pkg::REG_FREE_TOP:    free_top_q    <= cfg_data_i[COORD_WIDTH-1:0];
        bes_pkg::REG_FREE_RIGHT:  free_right_q  <= cfg_data_i[COORD_WIDTH-1:0];
        bes_pkg::REG_FREE_BOTTOM: free_bottom_q <= cfg_data_i[COORD_WIDTH-1:0];
        bes_pkg::REG_THRESHOLD:   thr_q         <= cfg_data_i[bes_pkg::THR_WIDTH-1:0];
        bes_pkg::REG_EDGE_MASK:   edge_mask_q   <= cfg_data_i[bes_pkg::MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q        <= req_type_i;
      box_left_q   <= box_left_i;
      box_top_q    <= box_top_i;
      box_right_q  <= box_right_i;
      box_bottom_q <= box_bottom_i;
    end
  end

  // Offer control
  assign g        = DW'(thr_q);
  assign is_start = (req_q == bes_pkg::REQ_START);
  assign near_v   = (DW'(box_top_q) <= DW'(free_bottom_q) + g) &&
                    (DW'(free_top_q) <= DW'(box_bottom_q) + g);
  assign near_h   = (DW'(box_left_q) <= DW'(free_right_q) + g) &&
                    (DW'(free_left_q) <= DW'(box_right_q) + g);

  always_comb begin
    slot_fix[bes_pkg::OFS_LEFT]     = free_left_q;
    slot_own[bes_pkg::OFS_LEFT]     = box_left_q;
    slot_other[bes_pkg::OFS_LEFT]   = box_right_q;
    slot_fix[bes_pkg::OFS_RIGHT]    = free_right_q;
    slot_own[bes_pkg::OFS_RIGHT]    = box_right_q;
    slot_other[bes_pkg::OFS_RIGHT]  = box_left_q;
    slot_fix[bes_pkg::OFS_TOP]      = free_top_q;
    slot_own[bes_pkg::OFS_TOP]      = box_top_q;
    slot_other[bes_pkg::OFS_TOP]    = box_bottom_q;
    slot_fix[bes_pkg::OFS_BOTTOM]   = free_bottom_q;
    slot_own[bes_pkg::OFS_BOTTOM]   = box_bottom_q;
    slot_other[bes_pkg::OFS_BOTTOM] = box_top_q;
    for (int s = 0; s < bes_pkg::NUM_SLOTS; s++) begin
      slot_ctl[s].clear    = is_start;
      slot_ctl[s].en_own   = is_start ||
                             ((s < bes_pkg::OFS_TOP) ? near_v : near_h);
      slot_ctl[s].en_other = !is_start &&
                             ((s < bes_pkg::OFS_TOP) ? near_v : near_h);
    end
  end

  for (genvar s = 0; s < bes_pkg::NUM_SLOTS; s++) begin : g_slot
    bes_slot #(
      .COORD_WIDTH (COORD_WIDTH),
      .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .update_i(advance),
      .ctl_i   (slot_ctl[s]),
      .thr_i   (thr_q),
      .fix_i   (slot_fix[s]),
      .own_i   (slot_own[s]),
      .other_i (slot_other[s]),
      .found_o (slot_found[s]),
      .best_o  (slot_best[s])
    );
  end

  // Snapped box
  always_comb begin
    dx = choose(slot_found[bes_pkg::OFS_LEFT], slot_best[bes_pkg::OFS_LEFT],
                slot_found[bes_pkg::OFS_RIGHT], slot_best[bes_pkg::OFS_RIGHT]);
    dy = choose(slot_found[bes_pkg::OFS_TOP], slot_best[bes_pkg::OFS_TOP],
                slot_found[bes_pkg::OFS_BOTTOM], slot_best[bes_pkg::OFS_BOTTOM]);
    snap_left_d   = free_left_q;
    snap_top_d    = free_top_q;
    snap_right_d  = free_right_q;
    snap_bottom_d = free_bottom_q;
    if (thr_q != bes_pkg::THR_OFF) begin
      if (edge_mask_q == bes_pkg::EDGE_ALL) begin
        snap_left_d   = sat(DW'(free_left_q) + dx);
        snap_right_d  = sat(DW'(free_right_q) + dx);
        snap_top_d    = sat(DW'(free_top_q) + dy);
        snap_bottom_d = sat(DW'(free_bottom_q) + dy);
      end else begin
        if (edge_mask_q[bes_pkg::EDGE_BIT_LEFT] && slot_found[bes_pkg::OFS_LEFT]) begin
          snap_left_d = sat(DW'(free_left_q) + DW'(slot_best[bes_pkg::OFS_LEFT]));
        end
        if (edge_mask_q[bes_pkg::EDGE_BIT_RIGHT] && slot_found[bes_pkg::OFS_RIGHT]) begin
          snap_right_d = sat(DW'(free_right_q) + DW'(slot_best[bes_pkg::OFS_RIGHT]));
        end
        if (edge_mask_q[bes_pkg::EDGE_BIT_TOP] && slot_found[bes_pkg::OFS_TOP]) begin
          snap_top_d = sat(DW'(free_top_q) + DW'(slot_best[bes_pkg::OFS_TOP]));
        end
        if (edge_mask_q[bes_pkg::EDGE_BIT_BOTTOM] && slot_found[bes_pkg::OFS_BOTTOM]) begin
          snap_bottom_d = sat(DW'(free_bottom_q) + DW'(slot_best[bes_pkg::OFS_BOTTOM]));
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      snap_left_q   <= snap_left_d;
      snap_top_q    <= snap_top_d;
      snap_right_q  <= snap_right_d;
      snap_bottom_q <= snap_bottom_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign snap_left_o   = snap_left_q;
  assign snap_top_o    = snap_top_q;
  assign snap_right_o  = snap_right_q;
  assign snap_bottom_o = snap_bottom_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("beat left input register without reaching output register");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  a_no_snap_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ((thr_q == bes_pkg::THR_OFF) || (edge_mask_q == '0))) |=>
      (snap_left_o == $past(free_left_q)) && (snap_top_o == $past(free_top_q)) &&
      (snap_right_o == $past(free_right_q)) && (snap_bottom_o == $past(free_bottom_q)))
    else $error("box moved with snapping disabled");

  a_move_keeps_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (edge_mask_q == bes_pkg::EDGE_ALL) && (dx == '0) && (dy == '0)) |=>
      (snap_left_o == $past(free_left_q)) && (snap_top_o == $past(free_top_q)))
    else $error("move mode shifted box with zero offsets");

endmodule

/* verif/snap_checker.sv */
// Checker for box_edge_snap: watches all three channels, predicts each snapped box, compares.
module snap_checker #(
  parameter int COORD_WIDTH  = 16,
  parameter int OFFSET_WIDTH = 13,
  parameter int CFG_WIDTH    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bes_pkg::IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [CFG_WIDTH-1:0]           cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           req_type_i,
  input  logic signed [COORD_WIDTH-1:0]  box_left_i,
  input  logic signed [COORD_WIDTH-1:0]  box_top_i,
  input  logic signed [COORD_WIDTH-1:0]  box_right_i,
  input  logic signed [COORD_WIDTH-1:0]  box_bottom_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic signed [COORD_WIDTH-1:0]  snap_left_i,
  input  logic signed [COORD_WIDTH-1:0]  snap_top_i,
  input  logic signed [COORD_WIDTH-1:0]  snap_right_i,
  input  logic signed [COORD_WIDTH-1:0]  snap_bottom_i,
  output int                             due_count_o,
  output int                             fail_count_o
);

  localparam int COORD_MAX = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] left;
    logic signed [COORD_WIDTH-1:0] top;
    logic signed [COORD_WIDTH-1:0] right;
    logic signed [COORD_WIDTH-1:0] bottom;
  } snap_box_t;

  logic signed [COORD_WIDTH-1:0]   drag_left, drag_top, drag_right, drag_bottom;
  logic [bes_pkg::THR_WIDTH-1:0]   snap_thr;
  logic [bes_pkg::MASK_WIDTH-1:0]  edge_en;
  logic signed [OFFSET_WIDTH-1:0]  kept_off [bes_pkg::NUM_SLOTS];
  logic                            kept_valid [bes_pkg::NUM_SLOTS];
  snap_box_t                       snapped_box_q [$];
  int                              fails = 0;

  assign fail_count_o = fails;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(int v);
    int c;
    c = v;
    if (c > COORD_MAX) c = COORD_MAX;
    if (c < COORD_MIN) c = COORD_MIN;
    return c[COORD_WIDTH-1:0];
  endfunction

  // Keep an offset when it is within the threshold and strictly closer than the kept one.
  task automatic offer_edge(int slot, int edge_pos, int cand);
    int off;
    off = cand - edge_pos;
    if (mag(off) > int'(snap_thr)) return;
    if (kept_valid[slot] && mag(off) >= mag(int'(kept_off[slot]))) return;
    kept_off[slot] = off[OFFSET_WIDTH-1:0];
    kept_valid[slot] = 1'b1;
  endtask

  function automatic int axis_shift(int lo, int hi);
    if (kept_valid[lo] && kept_valid[hi])
      return (mag(int'(kept_off[hi])) < mag(int'(kept_off[lo]))) ?
             int'(kept_off[hi]) : int'(kept_off[lo]);
    if (kept_valid[lo]) return int'(kept_off[lo]);
    if (kept_valid[hi]) return int'(kept_off[hi]);
    return 0;
  endfunction

  task automatic fold_box_and_snap();
    int fl, ft, fr, fb, bl, bt, br, bb, g, rl, rt, rr, rb, dx, dy;
    snap_box_t want;
    fl = int'(drag_left);
    ft = int'(drag_top);
    fr = int'(drag_right);
    fb = int'(drag_bottom);
    bl = int'(box_left_i);
    bt = int'(box_top_i);
    br = int'(box_right_i);
    bb = int'(box_bottom_i);
    g  = int'(snap_thr);
    rl = fl;
    rt = ft;
    rr = fr;
    rb = fb;
    if (req_type_i == bes_pkg::REQ_START) begin
      for (int i = 0; i < bes_pkg::NUM_SLOTS; i++) kept_valid[i] = 1'b0;
      offer_edge(bes_pkg::OFS_LEFT, fl, bl);
      offer_edge(bes_pkg::OFS_RIGHT, fr, br);
      offer_edge(bes_pkg::OFS_TOP, ft, bt);
      offer_edge(bes_pkg::OFS_BOTTOM, fb, bb);
    end else begin
      if (bt <= fb + g && ft <= bb + g) begin
        offer_edge(bes_pkg::OFS_LEFT, fl, bl);
        offer_edge(bes_pkg::OFS_LEFT, fl, br);
        offer_edge(bes_pkg::OFS_RIGHT, fr, br);
        offer_edge(bes_pkg::OFS_RIGHT, fr, bl);
      end
      if (bl <= fr + g && fl <= br + g) begin
        offer_edge(bes_pkg::OFS_TOP, ft, bt);
        offer_edge(bes_pkg::OFS_TOP, ft, bb);
        offer_edge(bes_pkg::OFS_BOTTOM, fb, bb);
        offer_edge(bes_pkg::OFS_BOTTOM, fb, bt);
      end
    end
    if (snap_thr != bes_pkg::THR_OFF) begin
      if (edge_en == bes_pkg::EDGE_ALL) begin
        dx = axis_shift(bes_pkg::OFS_LEFT, bes_pkg::OFS_RIGHT);
        dy = axis_shift(bes_pkg::OFS_TOP, bes_pkg::OFS_BOTTOM);
        rl = fl + dx;
        rr = fr + dx;
        rt = ft + dy;
        rb = fb + dy;
      end else begin
        if (edge_en[bes_pkg::EDGE_BIT_LEFT] && kept_valid[bes_pkg::OFS_LEFT])
          rl = fl + int'(kept_off[bes_pkg::OFS_LEFT]);
        if (edge_en[bes_pkg::EDGE_BIT_RIGHT] && kept_valid[bes_pkg::OFS_RIGHT])
          rr = fr + int'(kept_off[bes_pkg::OFS_RIGHT]);
        if (edge_en[bes_pkg::EDGE_BIT_TOP] && kept_valid[bes_pkg::OFS_TOP])
          rt = ft + int'(kept_off[bes_pkg::OFS_TOP]);
        if (edge_en[bes_pkg::EDGE_BIT_BOTTOM] && kept_valid[bes_pkg::OFS_BOTTOM])
          rb = fb + int'(kept_off[bes_pkg::OFS_BOTTOM]);
      end
    end
    want.left   = clamp_coord(rl);
    want.top    = clamp_coord(rt);
    want.right  = clamp_coord(rr);
    want.bottom = clamp_coord(rb);
    snapped_box_q.push_back(want);
  endtask

  task automatic check_coord(string name, logic signed [COORD_WIDTH-1:0] want,
                             logic signed [COORD_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    snap_box_t want;
    if (!rst_ni) begin
      drag_left   = '0;
      drag_top    = '0;
      drag_right  = '0;
      drag_bottom = '0;
      snap_thr    = '0;
      edge_en     = bes_pkg::EDGE_ALL;
      for (int i = 0; i < bes_pkg::NUM_SLOTS; i++) kept_valid[i] = 1'b0;
      snapped_box_q.delete();
      due_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bes_pkg::REG_FREE_LEFT:   drag_left   = cfg_data_i[COORD_WIDTH-1:0];
          bes_pkg::REG_FREE_TOP:    drag_top    = cfg_data_i[COORD_WIDTH-1:0];
          bes_pkg::REG_FREE_RIGHT:  drag_right  = cfg_data_i[COORD_WIDTH-1:0];
          bes_pkg::REG_FREE_BOTTOM: drag_bottom = cfg_data_i[COORD_WIDTH-1:0];
          bes_pkg::REG_THRESHOLD:   snap_thr    = cfg_data_i[bes_pkg::THR_WIDTH-1:0];
          bes_pkg::REG_EDGE_MASK:   edge_en     = cfg_data_i[bes_pkg::MASK_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (snapped_box_q.size() == 0) begin
          $error("snapped box beat with no expectation waiting");
          fails++;
        end else begin
          want = snapped_box_q.pop_front();
          check_coord("snap_left", want.left, snap_left_i);
          check_coord("snap_top", want.top, snap_top_i);
          check_coord("snap_right", want.right, snap_right_i);
          check_coord("snap_bottom", want.bottom, snap_bottom_i);
        end
      end
      if (in_valid_i && in_ready_i) fold_box_and_snap();
      due_count_o <= snapped_box_q.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for box_edge_snap: clock, reset, register writes, box stimulus and verdict.
module tb_top;

  localparam int COORD_WIDTH  = 16;
  localparam int OFFSET_WIDTH = 13;
  localparam int CFG_WIDTH    = (COORD_WIDTH > bes_pkg::THR_WIDTH) ?
                                COORD_WIDTH : bes_pkg::THR_WIDTH;
  localparam int COORD_MAX    = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int COORD_MIN    = -COORD_MAX - 1;
  localparam int CYCLE_LIMIT  = 400000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [bes_pkg::IDX_WIDTH-1:0] cfg_index_i;
  logic [CFG_WIDTH-1:0]          cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          req_type_i;
  logic signed [COORD_WIDTH-1:0] box_left_i, box_top_i, box_right_i, box_bottom_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [COORD_WIDTH-1:0] snap_left_o, snap_top_o, snap_right_o, snap_bottom_o;

  int due_count;
  int fail_count;
  int cycle_count = 0;
  int boxes_sent = 0;
  int settings_done = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  box_edge_snap #(
    .COORD_WIDTH (COORD_WIDTH),
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) dut (.*);

  snap_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .CFG_WIDTH   (CFG_WIDTH)
  ) snap_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .req_type_i   (req_type_i),
    .box_left_i   (box_left_i),
    .box_top_i    (box_top_i),
    .box_right_i  (box_right_i),
    .box_bottom_i (box_bottom_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .snap_left_i  (snap_left_o),
    .snap_top_i   (snap_top_o),
    .snap_right_i (snap_right_o),
    .snap_bottom_i(snap_bottom_o),
    .due_count_o  (due_count),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic int jitter(int base, int spread);
    return clamp_coord(base + $urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic int any_coord();
    logic signed [COORD_WIDTH-1:0] v;
    v = COORD_WIDTH'($urandom);
    return int'(v);
  endfunction

  task automatic write_reg(bes_pkg::cfg_reg_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_WIDTH-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Drop valid, then hold until every predicted box has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(int l, int t, int r, int b, int thr, int mask);
    wait_drained();
    write_reg(bes_pkg::REG_FREE_LEFT, l);
    write_reg(bes_pkg::REG_FREE_TOP, t);
    write_reg(bes_pkg::REG_FREE_RIGHT, r);
    write_reg(bes_pkg::REG_FREE_BOTTOM, b);
    write_reg(bes_pkg::REG_THRESHOLD, thr);
    write_reg(bes_pkg::REG_EDGE_MASK, mask);
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  task automatic send_box(bes_pkg::req_type_e req, int l, int t, int r, int b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    box_left_i   <= l[COORD_WIDTH-1:0];
    box_top_i    <= t[COORD_WIDTH-1:0];
    box_right_i  <= r[COORD_WIDTH-1:0];
    box_bottom_i <= b[COORD_WIDTH-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    boxes_sent++;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
  endtask

  task automatic run_snap_phase(int n_items);
    int fl, ft, fr, fb, thr, mask, spread, sent, choice, k;
    choice = $urandom_range(0, 5);
    case (choice)
      0: thr = 0;
      1: thr = 1;
      2: thr = 4095;
      5: thr = $urandom_range(0, 4095);
      default: thr = $urandom_range(2, 64);
    endcase
    mask = ($urandom_range(0, 2) == 0) ? int'(bes_pkg::EDGE_ALL) : $urandom_range(0, 15);
    fl = $urandom_range(0, 60000) - 30000;
    ft = $urandom_range(0, 60000) - 30000;
    fr = clamp_coord(fl + $urandom_range(1, 2000));
    fb = clamp_coord(ft + $urandom_range(1, 2000));
    choice = $urandom_range(0, 7);
    if (choice == 0) begin
      fl = any_coord();
      ft = any_coord();
      fr = any_coord();
      fb = any_coord();
    end else if (choice == 1) begin
      fl = COORD_MIN;
      ft = COORD_MIN;
      fr = COORD_MAX;
      fb = COORD_MAX;
    end
    spread = thr + 4;
    apply_setting(fl, ft, fr, fb, thr, mask);
    sent = 0;
    while (sent < n_items) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        send_box(bes_pkg::req_type_e'($urandom_range(0, 1)), any_coord(), any_coord(),
                 any_coord(), any_coord());
        sent++;
      end else begin
        // without a start the neighbors fold into whatever marks are left over
        if (choice != 1) begin
          if ($urandom_range(0, 3) == 0)
            send_box(bes_pkg::REQ_START, any_coord(), any_coord(), any_coord(), any_coord());
          else
            send_box(bes_pkg::REQ_START, jitter(fl, spread), jitter(ft, spread),
                     jitter(fr, spread), jitter(fb, spread));
          sent++;
        end
        k = $urandom_range(2, 10);
        repeat (k) begin
          send_box(bes_pkg::REQ_NEIGHBOR,
                   jitter($urandom_range(0, 1) ? fl : fr, spread),
                   jitter($urandom_range(0, 1) ? ft : fb, spread),
                   jitter($urandom_range(0, 1) ? fl : fr, spread),
                   jitter($urandom_range(0, 1) ? ft : fb, spread));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = bes_pkg::REG_FREE_LEFT;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    req_type_i   = bes_pkg::REQ_START;
    box_left_i   = '0;
    box_top_i    = '0;
    box_right_i  = '0;
    box_bottom_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // move mode, small threshold; first beat is a neighbor before any start
    apply_setting(100, 200, 300, 400, 16, int'(bes_pkg::EDGE_ALL));
    send_box(bes_pkg::REQ_NEIGHBOR, 110, 210, 290, 390);
    send_box(bes_pkg::REQ_START, 0, 0, 1919, 1079);
    send_box(bes_pkg::REQ_START, 90, 195, 316, 417);
    send_box(bes_pkg::REQ_NEIGHBOR, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_box(bes_pkg::REQ_NEIGHBOR, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_box(bes_pkg::REQ_START, 95, 200, 305, 400);
    send_box(bes_pkg::REQ_NEIGHBOR, 304, 180, 500, 420);
    send_box(bes_pkg::REQ_NEIGHBOR, 0, 397, 100, 600);

    // edge mode on left and top only, then no edges enabled
    apply_setting(100, 200, 300, 400, 16,
                  (1 << bes_pkg::EDGE_BIT_LEFT) | (1 << bes_pkg::EDGE_BIT_TOP));
    send_box(bes_pkg::REQ_NEIGHBOR, 110, 210, 290, 390);
    send_box(bes_pkg::REQ_START, 84, 216, 316, 384);
    send_box(bes_pkg::REQ_NEIGHBOR, 99, 0, 301, 600);
    apply_setting(100, 200, 300, 400, 16, 0);
    send_box(bes_pkg::REQ_START, 95, 195, 305, 405);

    // saturation at both ends of the coordinate range
    apply_setting(COORD_MAX - 7, COORD_MIN, COORD_MAX, COORD_MIN + 8, 4095,
                  int'(bes_pkg::EDGE_ALL));
    send_box(bes_pkg::REQ_START, COORD_MAX, 0, 0, COORD_MIN);
    send_box(bes_pkg::REQ_NEIGHBOR, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);

    // zero threshold leaves the box alone, then the smallest nonzero one
    apply_setting(-5, -5, 5, 5, int'(bes_pkg::THR_OFF), int'(bes_pkg::EDGE_ALL));
    send_box(bes_pkg::REQ_START, -5, -5, 5, 5);
    send_box(bes_pkg::REQ_NEIGHBOR, -4, -4, 6, 6);
    apply_setting(-5, -5, 5, 5, 1, int'(bes_pkg::EDGE_ALL));
    send_box(bes_pkg::REQ_START, -6, -4, 6, 4);

    for (int p = 0; p < 10; p++) run_snap_phase(80);

    wait_drained();
    $display("%0d boxes sent under %0d register settings", boxes_sent, settings_done);
    $display("threshold and mask extremes, move ties and saturation covered");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bes_pkg.sv
hw/rtl/bes_slot.sv
hw/rtl/box_edge_snap.sv
verif/snap_checker.sv
verif/tb_top.sv
